// ----- src/assert_macros.svh -----
// Assertion macros for the compressor modules; only the back end uses them.
// Depends on nothing; modules take it by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold in the same cycle as its trigger.
`define ASSERT_SAME(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- src/lzwc_pkg.sv -----
// Package of the LZW compressor: widths, constants, transaction types and the hash.
// Depends on nothing; every module imports it.
package lzwc_pkg;

   localparam int CODE_BITS   = 12;
   localparam int BYTE_BITS   = 8;
   localparam int KEY_BITS    = CODE_BITS + BYTE_BITS;
   localparam int FIRST_CODE  = 256;
   localparam int CODE_LIMIT  = 1 << CODE_BITS;
   localparam int TABLE_DEPTH = CODE_LIMIT;
   localparam int EPOCH_BITS  = 8;
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS  = PTR_BITS + 1;

   typedef struct packed {
      logic [BYTE_BITS-1:0] data_byte;
      logic                 end_of_line;
   } req_type;

   typedef struct packed {
      logic [CODE_BITS-1:0] out_code;
      logic                 last_code;
   } rsp_type;

   typedef struct packed {
      req_type req;
      logic    first;
   } work_type;

   typedef struct packed {
      logic     valid;
      work_type work;
   } work_queue_type;

   typedef struct packed {
      logic [EPOCH_BITS-1:0] epoch;
      logic [KEY_BITS-1:0]   key;
      logic [CODE_BITS-1:0]  code;
   } slot_type;

   typedef struct packed {
      logic room;
   } out_status_type;

   typedef struct packed {
      logic sweeping;
   } back_status_type;

   function automatic logic [CODE_BITS-1:0] slot_hash(input logic [CODE_BITS-1:0] phrase,
                                                      input logic [BYTE_BITS-1:0] data);
      return phrase ^ (CODE_BITS'(data) << (CODE_BITS - BYTE_BITS));
   endfunction

endpackage

// ----- src/lzwc_front.sv -----
// Front end: accepts bytes, marks the first byte of each line, and queues them.
// Depends on lzwc_pkg.
module lzwc_front
   import lzwc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  req_type        req_data,
   input  logic           blocked,
   output logic           full,
   input  logic           pop,
   output work_queue_type head
);

   work_type               slots_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic                   in_line_ff, in_line_in;
   logic                   accept;
   logic                   take;

   assign full   = (count_ff == COUNT_BITS'(QUEUE_DEPTH)) || blocked;
   assign accept = push && !full;
   assign take   = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.work  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in  = accept ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in   = count_ff + COUNT_BITS'(accept) - COUNT_BITS'(take);
      in_line_in = accept ? !req_data.end_of_line : in_line_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
         in_line_ff <= 1'b0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         count_ff   <= count_in;
         in_line_ff <= in_line_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slots_ff[wr_ptr_ff].req   <= req_data;
         slots_ff[wr_ptr_ff].first <= !in_line_ff;
      end
   end

endmodule

// ----- src/lzwc_out.sv -----
// Result queue: holds emitted codes until the consumer pops them.
// Depends on lzwc_pkg.
module lzwc_out
   import lzwc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  rsp_type        push_data,
   output out_status_type status,
   output logic           empty,
   input  logic           pop,
   output rsp_type        rsp_data
);

   rsp_type                slots_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic                   take;

   assign empty       = (count_ff == '0);
   assign take        = pop && !empty;
   assign rsp_data    = slots_ff[rd_ptr_ff];
   // Room for the two codes that one byte can produce.
   assign status.room = (count_ff <= COUNT_BITS'(QUEUE_DEPTH - 2));

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + COUNT_BITS'(push) - COUNT_BITS'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- src/lzwc_back.sv -----
// Back end: dictionary in a hashed table with linear probing, epoch-tagged per line.
// Depends on lzwc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module lzwc_back
   import lzwc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  work_queue_type  head,
   output logic            pop,
   input  out_status_type  out_status,
   output logic            out_push,
   output rsp_type         out_data,
   output back_status_type status
);

   typedef enum logic [4:0] {
      S_SWEEP = 5'b00001,
      S_IDLE  = 5'b00010,
      S_READ  = 5'b00100,
      S_CHECK = 5'b01000,
      S_LAST  = 5'b10000
   } state_type;

   slot_type               table_mem [TABLE_DEPTH];
   slot_type               rdata_ff;
   state_type              state_ff, state_in;
   logic [CODE_BITS-1:0]   phrase_ff, phrase_in;
   logic [CODE_BITS:0]     next_free_ff, next_free_in;
   logic [EPOCH_BITS-1:0]  epoch_ff, epoch_in;
   logic [CODE_BITS-1:0]   probe_ff, probe_in;
   logic [CODE_BITS-1:0]   sweep_ff, sweep_in;
   logic [KEY_BITS-1:0]    key_ff, key_in;
   logic [BYTE_BITS-1:0]   byte_ff, byte_in;
   logic                   eol_ff, eol_in;
   logic                   we;
   slot_type               wdata;
   logic [CODE_BITS-1:0]   waddr;
   logic                   stale;
   logic                   hit;
   logic                   has_room;

   assign stale           = (rdata_ff.epoch != epoch_ff);
   assign hit             = !stale && (rdata_ff.key == key_ff);
   assign has_room        = !next_free_ff[CODE_BITS];
   assign status.sweeping = (state_ff == S_SWEEP);

   always_comb begin
      state_in     = state_ff;
      phrase_in    = phrase_ff;
      next_free_in = next_free_ff;
      epoch_in     = epoch_ff;
      probe_in     = probe_ff;
      sweep_in     = sweep_ff;
      key_in       = key_ff;
      byte_in      = byte_ff;
      eol_in       = eol_ff;
      pop          = 1'b0;
      out_push     = 1'b0;
      out_data     = '{out_code: phrase_ff, last_code: 1'b0};
      we           = 1'b0;
      waddr        = probe_ff;
      wdata        = '{epoch: epoch_ff, key: key_ff, code: next_free_ff[CODE_BITS-1:0]};
      case (state_ff)
         S_SWEEP: begin
            we       = 1'b1;
            waddr    = sweep_ff;
            wdata    = '{epoch: '0, key: '0, code: '0};
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (head.valid && out_status.room) begin
               pop     = 1'b1;
               byte_in = head.work.req.data_byte;
               eol_in  = head.work.req.end_of_line;
               key_in  = {phrase_ff, head.work.req.data_byte};
               if (head.work.first) begin
                  phrase_in = CODE_BITS'(head.work.req.data_byte);
                  state_in  = head.work.req.end_of_line ? S_LAST : S_IDLE;
               end else begin
                  probe_in = slot_hash(phrase_ff, head.work.req.data_byte);
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (hit) begin
               phrase_in = rdata_ff.code;
               state_in  = eol_ff ? S_LAST : S_IDLE;
            end else if (stale) begin
               out_push  = 1'b1;
               phrase_in = CODE_BITS'(byte_ff);
               if (has_room) begin
                  we           = 1'b1;
                  next_free_in = next_free_ff + 1'b1;
               end
               state_in = eol_ff ? S_LAST : S_IDLE;
            end else begin
               probe_in = probe_ff + 1'b1;
               state_in = S_READ;
            end
         end
         S_LAST: begin
            out_push     = 1'b1;
            out_data     = '{out_code: phrase_ff, last_code: 1'b1};
            phrase_in    = '0;
            next_free_in = (CODE_BITS + 1)'(FIRST_CODE);
            // Epoch zero marks swept slots, so a wrap forces a new sweep.
            if (epoch_ff == '1) begin
               epoch_in = EPOCH_BITS'(1);
               sweep_in = '0;
               state_in = S_SWEEP;
            end else begin
               epoch_in = epoch_ff + 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_SWEEP;
            sweep_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         sweep_ff     <= '0;
         epoch_ff     <= EPOCH_BITS'(1);
         phrase_ff    <= '0;
         next_free_ff <= (CODE_BITS + 1)'(FIRST_CODE);
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         epoch_ff     <= epoch_in;
         phrase_ff    <= phrase_in;
         next_free_ff <= next_free_in;
      end
   end

   always_ff @(posedge clock) begin
      probe_ff <= probe_in;
      key_ff   <= key_in;
      byte_ff  <= byte_in;
      eol_ff   <= eol_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         table_mem[waddr] <= wdata;
      end
      rdata_ff <= table_mem[probe_ff];
   end

   `ASSERT_SAME(a_push_state, clock, reset, out_push, (state_ff == S_CHECK || state_ff == S_LAST), "code emitted outside a check or line end")
   `ASSERT_SAME(a_free_bound, clock, reset, 1'b1, (next_free_ff <= (CODE_BITS + 1)'(CODE_LIMIT)), "next free code beyond the limit")
   `ASSERT_SAME(a_epoch_live, clock, reset, 1'b1, (epoch_ff != '0), "live epoch collides with swept slots")
   `ASSERT_NEXT(a_last_exit, clock, reset, (state_ff == S_LAST), (state_ff == S_IDLE || state_ff == S_SWEEP), "line end did not return to idle or sweep")

endmodule

// ----- src/lzw_compressor.sv -----
// LZW line compressor. A byte that starts a line needs only the idle state; any other
// byte probes the hashed dictionary table (one table read port) in the read and check
// states once per probe, and a line end adds the line-end state, which pushes the last
// code of the line (the literal, for a one-byte line); any other code is pushed from the
// check state. Reset is synchronous; after reset, and after every 255 lines when the line
// tag wraps, a sweep of all 4096 table slots tags the table stale while full stays high.
module lzw_compressor
   import lzwc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   // The front end queues bytes and flags the first byte of every line, so the
   // back end needs no knowledge of the input handshake.
   work_queue_type  head;
   logic            head_pop;
   back_status_type back_status;
   out_status_type  out_status;
   logic            out_push;
   rsp_type         out_data;

   lzwc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .blocked  (back_status.sweeping),
      .full     (full),
      .pop      (head_pop),
      .head     (head)
   );

   // The back end runs the dictionary: lookup by linear probing from a hash of the
   // phrase code and byte, insert on a miss while free codes remain, and a new line tag
   // at each line end so that the table needs a sweep only when the line tag wraps.
   lzwc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (head_pop),
      .out_status (out_status),
      .out_push   (out_push),
      .out_data   (out_data),
      .status     (back_status)
   );

   // The result queue lets the consumer stall without holding up the back end
   // until it runs out of room for two codes.
   lzwc_out u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .status    (out_status),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule
